>>> src/avst_pkg.sv
package avst_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TRIGGER_LEVEL = 3'd0,
    CFG_SINK_RATE     = 3'd1,
    CFG_TRIGGER_TIME  = 3'd2,
    CFG_RELAX_TIME    = 3'd3,
    CFG_MIN_SMOOTH    = 3'd4,
    CFG_MAX_SMOOTH    = 3'd5,
    CFG_START_SMOOTH  = 3'd6,
    CFG_UNUSED        = 3'd7
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [15:0] TRIGGER_LEVEL_RST = 16'd300;
  localparam logic [15:0] SINK_RATE_RST     = 16'd1000;
  localparam logic [30:0] TRIGGER_TIME_RST  = 31'd1000;
  localparam logic [30:0] RELAX_TIME_RST    = 31'd5000;
  localparam logic [7:0]  MIN_SMOOTH_RST    = 8'd5;
  localparam logic [7:0]  MAX_SMOOTH_RST    = 8'd50;
  localparam logic [7:0]  START_SMOOTH_RST  = 8'd20;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Live configuration seen by the front and the back.
  typedef struct packed {
    logic [15:0] trigger_level;
    logic [15:0] sink_rate;
    logic [30:0] trigger_time;
    logic [30:0] relax_time;
    logic [7:0]  min_smooth;
    logic [7:0]  max_smooth;
  } cfg_t;

  // One classified sample as it travels from front to back.
  typedef struct packed {
    logic        above;
    logic        below;
    logic [31:0] now_ms;
  } item_t;

endpackage

>>> src/adaptive_vario_smoothing_tuner.sv
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_stall     climb_rate, in_flight, now_ms
// out_      output     out_valid / out_stall   smooth_level, armed
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One sample per cycle is sustained while out_stall stays low; a sample passes
// through a queue slot, then the back stage updates its state into the output register.
// A two-entry queue separates classification from the state update, so the
// input takes up to two more samples while one result waits under out_stall.
// Reset is synchronous and active low; it restores all registers but the queue
// slots and result payload, and loads the start smoothing level. cfg_ready is always high.
module adaptive_vario_smoothing_tuner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_climb_rate,
  input  logic               in_in_flight,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_smooth_level,
  output logic               out_armed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  avst_pkg::cfg_t  cfg_r;
  logic            push;
  avst_pkg::item_t push_item;
  logic            queue_full;
  logic            pop;
  logic            not_empty;
  avst_pkg::item_t pop_item;

  assign cfg_ready = 1'b1;

  // Configuration registers. The start level is loaded only by reset, and a
  // reset also restores its default, so a written value is never observed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_level <= avst_pkg::TRIGGER_LEVEL_RST;
      cfg_r.sink_rate     <= avst_pkg::SINK_RATE_RST;
      cfg_r.trigger_time  <= avst_pkg::TRIGGER_TIME_RST;
      cfg_r.relax_time    <= avst_pkg::RELAX_TIME_RST;
      cfg_r.min_smooth    <= avst_pkg::MIN_SMOOTH_RST;
      cfg_r.max_smooth    <= avst_pkg::MAX_SMOOTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (avst_pkg::cfg_idx_t'(cfg_index))
        avst_pkg::CFG_TRIGGER_LEVEL: cfg_r.trigger_level <= cfg_data[15:0];
        avst_pkg::CFG_SINK_RATE:     cfg_r.sink_rate     <= cfg_data[15:0];
        avst_pkg::CFG_TRIGGER_TIME:  cfg_r.trigger_time  <= cfg_data;
        avst_pkg::CFG_RELAX_TIME:    cfg_r.relax_time    <= cfg_data;
        avst_pkg::CFG_MIN_SMOOTH:    cfg_r.min_smooth    <= cfg_data[7:0];
        avst_pkg::CFG_MAX_SMOOTH:    cfg_r.max_smooth    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  avst_front u_front (
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_climb_rate (in_climb_rate),
    .in_in_flight  (in_in_flight),
    .in_now_ms     (in_now_ms),
    .push          (push),
    .push_item     (push_item),
    .queue_full    (queue_full)
  );

  avst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  avst_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .not_empty        (not_empty),
    .pop_item         (pop_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_smooth_level (out_smooth_level),
    .out_armed        (out_armed)
  );

endmodule

>>> src/avst_front.sv
module avst_front (
  input  avst_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_climb_rate,
  input  logic               in_in_flight,
  input  logic [31:0]        in_now_ms,
  output logic               push,
  output avst_pkg::item_t    push_item,
  input  logic               queue_full
);

  logic signed [17:0] rate_ext;
  logic signed [17:0] sink_ext;
  logic signed [17:0] rate_comp;
  logic [16:0]        mag;
  logic [16:0]        thr;

  // Sink compensation while flying, then magnitude.
  always_comb begin
    rate_ext  = 18'(in_climb_rate);
    sink_ext  = in_in_flight ? $signed({2'b00, cfg.sink_rate}) : 18'sd0;
    rate_comp = rate_ext - sink_ext;
    mag       = rate_comp[17] ? 17'(-rate_comp) : rate_comp[16:0];
    thr       = {1'b0, cfg.trigger_level};
  end

  // Classify against the threshold and hand the sample to the queue.
  always_comb begin
    push_item.above  = (mag > thr);
    push_item.below  = (mag < thr);
    push_item.now_ms = in_now_ms;
    push             = in_valid && !queue_full;
    in_stall         = queue_full;
  end

endmodule

>>> src/avst_queue.sv
module avst_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  avst_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output avst_pkg::item_t pop_item
);

  avst_pkg::item_t                    slot_r [avst_pkg::QUEUE_DEPTH];
  logic [avst_pkg::QUEUE_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [avst_pkg::QUEUE_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [avst_pkg::QUEUE_CW-1:0]      count_r, count_nxt;

  assign full      = (count_r == avst_pkg::QUEUE_CW'(avst_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == avst_pkg::QUEUE_AW'(avst_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == avst_pkg::QUEUE_AW'(avst_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/avst_back.sv
module avst_back (
  input  logic            clk,
  input  logic            rst_n,
  input  avst_pkg::cfg_t  cfg,
  input  logic            not_empty,
  input  avst_pkg::item_t pop_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_smooth_level,
  output logic            out_armed
);

  logic        flag_r, flag_nxt;
  logic [31:0] mark_r, mark_nxt;
  logic [7:0]  level_r, level_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_level_r;
  logic        out_armed_r;

  logic               flag1, flag2;
  logic [31:0]        mark1;
  logic [7:0]         level2;
  logic signed [31:0] diff;
  logic signed [31:0] trig_win;
  logic signed [31:0] relax_win;

  // A new sample is taken whenever the output register is free or drains.
  assign pop = not_empty && (!out_valid_r || !out_stall);

  // Trigger, noise and relax checks in their fixed order.
  always_comb begin
    trig_win  = $signed({1'b0, cfg.trigger_time});
    relax_win = $signed({1'b0, cfg.relax_time});

    flag1 = flag_r;
    mark1 = mark_r;
    if (pop_item.above && !flag_r) begin
      flag1 = 1'b1;
      mark1 = pop_item.now_ms;
    end

    diff = $signed(pop_item.now_ms - mark1);

    flag2    = flag1;
    mark_nxt = mark1;
    level2   = level_r;
    if (flag1 && pop_item.below && (diff < trig_win) && (level_r <= cfg.max_smooth)) begin
      level2   = (level_r == 8'hFF) ? level_r : level_r + 8'd1;
      flag2    = 1'b0;
      mark_nxt = pop_item.now_ms;
    end

    flag_nxt = flag2;
    if ((diff > trig_win) && flag2) begin
      flag_nxt = 1'b0;
    end

    level_nxt = level2;
    if (pop_item.below && !flag_nxt && (diff > relax_win) && (level2 > cfg.min_smooth)) begin
      level_nxt = level2 - 8'd1;
      mark_nxt  = pop_item.now_ms;
    end
  end

  // Output register valid: set on a new sample, cleared once transferred.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= 1'b0;
      mark_r      <= '0;
      level_r     <= avst_pkg::START_SMOOTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        flag_r  <= flag_nxt;
        mark_r  <= mark_nxt;
        level_r <= level_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_level_r <= level_nxt;
      out_armed_r <= flag_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_smooth_level = out_level_r;
  assign out_armed        = out_armed_r;

endmodule

>>> src/avst_checker.sv
module avst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_smooth_level,
  input logic        out_armed
);

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_smooth_level) && $stable(out_armed))
    else $error("result changed while stalled");

  // A new result follows an input transfer that passed through the queue.
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(rst_n) |-> $past(in_xfer, 2))
    else $error("result appeared without a sample");

  // Back-to-back results never move the level by more than one step.
  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && $past(out_xfer) && $past(rst_n) |->
      (out_smooth_level == $past(out_smooth_level)) ||
      (out_smooth_level == $past(out_smooth_level) + 8'd1) ||
      ($past(out_smooth_level) == out_smooth_level + 8'd1))
    else $error("smoothing level jumped");

endmodule

bind adaptive_vario_smoothing_tuner avst_checker u_avst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_smooth_level (out_smooth_level),
  .out_armed        (out_armed)
);
